// ===== hw/rtl/ihpc_pkg.sv =====
// shared types, status codes and checksum fold for the ipv4 header parser
`default_nettype none

package ihpc_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_BAD_VERSION = 2'd1,
    STAT_CSUM_ERR    = 2'd2,
    STAT_SHORT_IHL   = 2'd3
  } status_t;

  localparam logic [3:0] VERSION_FOUR = 4'd4;
  localparam logic [3:0] MIN_IHL      = 4'd5;
  localparam int unsigned TDATA_IN_W  = 24;
  localparam int unsigned TDATA_OUT_W = 160;

  // one accepted input byte
  typedef struct packed {
    logic        sop;
    logic [15:0] len;
    logic [7:0]  data;
  } in_item_t;

  // one parse result
  typedef struct packed {
    status_t     status;
    logic [3:0]  header_words;
    logic [7:0]  service_type;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic [2:0]  frag_flags;
    logic [12:0] frag_offset;
    logic [7:0]  time_to_live;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] payload_len;
  } result_t;

  // fold a 21-bit ones'-complement sum twice and complement it
  function automatic logic [15:0] csum_fold(input logic [20:0] sum);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = {1'b0, sum[15:0]} + {12'b0, sum[20:16]};
    f2 = {1'b0, f1[15:0]} + {16'b0, f1[16]};
    return ~f2[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ihpc_in_reg.sv =====
// input register stage for the ipv4 header parser
`default_nettype none

module ihpc_in_reg
  import ihpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_valid,
  output logic          s_ready,
  input  wire in_item_t s_item,
  output logic          item_valid,
  output in_item_t      item,
  input  wire logic     take
);

  // free when empty or when the held byte moves on this cycle
  assign s_ready = !item_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_ready) begin
      item_valid <= s_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ihpc_core.sv =====
// header field capture, checksum accumulation and result register
`default_nettype none

module ihpc_core
  import ihpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  input  wire in_item_t item,
  output logic          take,
  output logic          res_valid,
  output result_t       res,
  input  wire logic     res_ready
);

  // parser state
  logic        parsing, parsing_next;
  logic [5:0]  byte_index, byte_index_next;
  logic [20:0] word_sum, word_sum_next;
  logic [7:0]  high_byte, high_byte_next;
  logic [15:0] given_checksum, given_checksum_next;
  logic [15:0] saved_len, saved_len_next;
  logic [3:0]  ihl, ihl_next;
  logic [7:0]  tos, tos_next;
  logic [15:0] tot_length, tot_length_next;
  logic [15:0] ident, ident_next;
  logic [15:0] frag_word, frag_word_next;
  logic [7:0]  ttl, ttl_next;
  logic [7:0]  proto, proto_next;
  logic [31:0] src, src_next;
  logic [31:0] dst, dst_next;

  logic        fire;
  logic        active;
  logic [5:0]  idx_cur;
  logic [20:0] sum_cur;
  logic        res_load;
  result_t     res_next;

  // result register frees when empty or being taken
  assign take = !res_valid || res_ready;
  assign fire = item_valid && take;

  always_comb begin
    parsing_next        = parsing;
    byte_index_next     = byte_index;
    word_sum_next       = word_sum;
    high_byte_next      = high_byte;
    given_checksum_next = given_checksum;
    saved_len_next      = saved_len;
    ihl_next            = ihl;
    tos_next            = tos;
    tot_length_next     = tot_length;
    ident_next          = ident;
    frag_word_next      = frag_word;
    ttl_next            = ttl;
    proto_next          = proto;
    src_next            = src;
    dst_next            = dst;
    res_load            = 1'b0;
    res_next            = '0;

    // a start marker restarts the header from its first byte
    idx_cur = item.sop ? 6'd0 : byte_index;
    sum_cur = item.sop ? 21'd0 : word_sum;
    active  = item.sop || parsing;

    if (fire) begin
      if (item.sop) begin
        parsing_next    = 1'b1;
        saved_len_next  = item.len;
        byte_index_next = 6'd0;
        word_sum_next   = 21'd0;
      end
      if (active) begin
        byte_index_next = idx_cur + 6'd1;

        // field capture by byte position
        case (idx_cur) inside
          6'd0:            ihl_next = item.data[3:0];
          6'd1:            tos_next = item.data;
          6'd2:            tot_length_next[15:8] = item.data;
          6'd3:            tot_length_next[7:0] = item.data;
          6'd4:            ident_next[15:8] = item.data;
          6'd5:            ident_next[7:0] = item.data;
          6'd6:            frag_word_next[15:8] = item.data;
          6'd7:            frag_word_next[7:0] = item.data;
          6'd8:            ttl_next = item.data;
          6'd9:            proto_next = item.data;
          [6'd10:6'd11]:   given_checksum_next = {given_checksum[7:0], item.data};
          [6'd12:6'd15]:   src_next = {src[23:0], item.data};
          [6'd16:6'd19]:   dst_next = {dst[23:0], item.data};
          default:         ;
        endcase

        // word sum, skipping the checksum word
        if (!idx_cur[0]) begin
          high_byte_next = item.data;
        end else if (idx_cur != 6'd11) begin
          word_sum_next = sum_cur + {5'b0, high_byte, item.data};
        end

        // early error on the first byte, otherwise result on the last header byte
        if (idx_cur == 6'd0 &&
            (item.data[7:4] != VERSION_FOUR || item.data[3:0] < MIN_IHL)) begin
          parsing_next          = 1'b0;
          res_load              = 1'b1;
          res_next.status       = (item.data[7:4] != VERSION_FOUR) ? STAT_BAD_VERSION
                                                                   : STAT_SHORT_IHL;
          res_next.header_words = item.data[3:0];
        end else if (idx_cur != 6'd0 && byte_index_next == {ihl, 2'b00}) begin
          parsing_next          = 1'b0;
          res_load              = 1'b1;
          res_next.status       = (csum_fold(word_sum_next) != given_checksum)
                                  ? STAT_CSUM_ERR : STAT_OK;
          res_next.header_words = ihl;
          res_next.service_type = tos;
          res_next.total_length = tot_length;
          res_next.ident        = ident;
          res_next.frag_flags   = frag_word[15:13];
          res_next.frag_offset  = frag_word[12:0];
          res_next.time_to_live = ttl;
          res_next.protocol     = proto;
          res_next.src_addr     = src;
          res_next.dst_addr     = dst_next;
          res_next.payload_len  = saved_len - {10'b0, ihl, 2'b00};
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      parsing    <= 1'b0;
      byte_index <= 6'd0;
      word_sum   <= 21'd0;
      res_valid  <= 1'b0;
    end else begin
      parsing    <= parsing_next;
      byte_index <= byte_index_next;
      word_sum   <= word_sum_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // captured fields and result payload
  always_ff @(posedge clk) begin
    high_byte      <= high_byte_next;
    given_checksum <= given_checksum_next;
    saved_len      <= saved_len_next;
    ihl            <= ihl_next;
    tos            <= tos_next;
    tot_length     <= tot_length_next;
    ident          <= ident_next;
    frag_word      <= frag_word_next;
    ttl            <= ttl_next;
    proto          <= proto_next;
    src            <= src_next;
    dst            <= dst_next;
    if (res_load) begin
      res <= res_next;
    end
  end

  // a new result only appears after a byte was consumed
  a_res_from_fire: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(fire))
    else $error("result appeared without a consumed byte");

  // the header never runs past sixty bytes
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    parsing |-> byte_index < 6'd60)
    else $error("byte index beyond header length");

  // a full parse result always has a legal header length
  a_full_ihl: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == STAT_OK || res.status == STAT_CSUM_ERR)
      |-> res.header_words >= MIN_IHL)
    else $error("full result with short header length");

  // an early error leaves the parser idle
  a_error_stops: assert property (@(posedge clk) disable iff (rst)
    fire && res_load && (res_next.status == STAT_BAD_VERSION ||
                         res_next.status == STAT_SHORT_IHL) |=> !parsing)
    else $error("parser still active after early error");

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4_header_parse_check.sv =====
// top level of the ipv4 header parser with header checksum check
//
//  channel  dir  tdata (low bit up)                          tuser
//  s_axis   in   data_byte[7:0] buffer_len[23:8]             start_of_packet
//  m_axis   out  header_words..payload_len, see port comment  status[1:0]
//
// one byte is taken per cycle, back to back, unless a result waits on m_axis;
// a result leaves after its last header byte passes the input, then result register
// the result register frees on the same cycle it is taken, so no bubble is
// lost under continuous output ready
// synchronous reset clears the parser to idle and empties both registers
// a stall on m_axis holds the result and backs up through the input register
`default_nettype none

module ipv4_header_parse_check
  import ihpc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // data_byte[7:0], buffer_len[23:8]
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,
  // start_of_packet
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // header_words[3:0], service_type[11:4], total_length[27:12], ident[43:28],
  // frag_flags[46:44], frag_offset[59:47], time_to_live[67:60],
  // protocol[75:68], src_addr[107:76], dst_addr[139:108],
  // payload_len[155:140], zero[159:156]
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]                  m_axis_tuser
);

  in_item_t s_item;
  in_item_t item;
  logic     item_valid;
  logic     take;
  result_t  res;

  // unpack the input transfer
  assign s_item.data = s_axis_tdata[7:0];
  assign s_item.len  = s_axis_tdata[23:8];
  assign s_item.sop  = s_axis_tuser;

  ihpc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  ihpc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res_valid  (m_axis_tvalid),
    .res        (res),
    .res_ready  (m_axis_tready)
  );

  // pack the output transfer
  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {4'b0, res.payload_len, res.dst_addr, res.src_addr,
                         res.protocol, res.time_to_live, res.frag_offset,
                         res.frag_flags, res.ident, res.total_length,
                         res.service_type, res.header_words};

endmodule

`default_nettype wire
